FILE: src/bfs_pkg.sv
// ----------------------------------------------------------------------------
// bfs_pkg - shared types and constants of the support-weighted bilateral filter
// Holds the fixed field widths, the exp table, the sequencer states and the
// divider status record.
// ----------------------------------------------------------------------------
package bfs_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = SAMPLE_BITS - 4;
  localparam int SUP_BITS    = 16;
  localparam int WORD_BITS   = SAMPLE_BITS + SUP_BITS;
  localparam int RANGE_SHIFT = 2 * FRAC_BITS - 8;
  localparam int OUT_POS_BITS = 8;

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_RADIUS = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPATIAL_SCALE = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_SCALE   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SUP_ENABLE    = 3'd4;

  // reset values and defaults
  localparam int DEF_MAX_TILE   = 256;
  localparam int DEF_MAX_RADIUS = 3;
  localparam logic [8:0]  RST_TILE_WIDTH    = 9'd128;
  localparam logic [1:0]  RST_WINDOW_RADIUS = 2'd3;
  localparam logic [31:0] RST_SPATIAL_SCALE = 32'd8388608;
  localparam logic [31:0] RST_RANGE_SCALE   = 32'd16777216;
  localparam logic [15:0] UNIT_SUPPORT      = 16'd256;

  // exponent argument: Q.16, capped at 16.0
  localparam int ARG_BITS = 21;
  localparam logic [ARG_BITS-1:0] ARG_CAP = 21'h100000;

  // exp table
  localparam int EXP_ENTRIES = 256;
  localparam int EXP_IW      = $clog2(EXP_ENTRIES);
  localparam int EXP_W       = 17;

  typedef logic [EXP_W-1:0] exp_tab_t [EXP_ENTRIES];

  function automatic exp_tab_t build_exp();
    exp_tab_t    tab;
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] q;
    logic [63:0] e;
    h    = (64'd16 << 30) / EXP_ENTRIES;
    term = 64'd1 << 30;
    pos  = term;
    neg  = 64'd0;
    term = ((term * h) >> 30) / 1;  neg = neg + term;
    term = ((term * h) >> 30) / 2;  pos = pos + term;
    term = ((term * h) >> 30) / 3;  neg = neg + term;
    term = ((term * h) >> 30) / 4;  pos = pos + term;
    term = ((term * h) >> 30) / 5;  neg = neg + term;
    term = ((term * h) >> 30) / 6;  pos = pos + term;
    term = ((term * h) >> 30) / 7;  neg = neg + term;
    term = ((term * h) >> 30) / 8;  pos = pos + term;
    term = ((term * h) >> 30) / 9;  neg = neg + term;
    term = ((term * h) >> 30) / 10; pos = pos + term;
    q = pos - neg;
    e = 64'd1 << 30;
    for (int i = 0; i < EXP_ENTRIES; i++) begin
      tab[i] = EXP_W'((e + (64'd1 << 13)) >> 14);
      e      = (e * q + (64'd1 << 29)) >> 30;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp();

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CREAD,
    ST_CCAP,
    ST_TREAD,
    ST_TCAP,
    ST_TMUL1,
    ST_TREL,
    ST_TRDIV,
    ST_TMUL2,
    ST_TMUL3,
    ST_TWGT,
    ST_TW,
    ST_TACC,
    ST_FDIV,
    ST_FWAIT,
    ST_DONE
  } state_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: src/bfs_if.sv
// ----------------------------------------------------------------------------
// bfs_if - item channels of the bilateral filter
// Input samples, filtered results and configuration writes, each with
// valid and ready.
// ----------------------------------------------------------------------------
interface bfs_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] sample;
  logic [15:0] support;
  logic        tile_first;
  modport source(output valid, sample, support, tile_first, input ready);
  modport sink(input valid, sample, support, tile_first, output ready);
endinterface

interface bfs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] filtered;
  logic [7:0]  center_col;
  logic [7:0]  center_row;
  logic        tile_last;
  modport source(output valid, filtered, center_col, center_row, tile_last, input ready);
  modport sink(input valid, filtered, center_col, center_row, tile_last, output ready);
endinterface

interface bfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

FILE: src/bfs_line_mem.sv
// ----------------------------------------------------------------------------
// bfs_line_mem - line store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bfs_line_mem #(
  parameter int DEPTH = 7 * bfs_pkg::DEF_MAX_TILE,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [bfs_pkg::WORD_BITS-1:0]  wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [bfs_pkg::WORD_BITS-1:0]  rdata
);

  logic [bfs_pkg::WORD_BITS-1:0] mem [DEPTH];

  // write the accepted item
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read one word a cycle
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/bfs_div.sv
// ----------------------------------------------------------------------------
// bfs_div - shared restoring divider
// One quotient bit a cycle; the caller guarantees the quotient fits Q_W bits.
// ----------------------------------------------------------------------------
module bfs_div #(
  parameter int DEN_W = 32,
  parameter int Q_W   = 16,
  parameter int NUM_W = DEN_W + Q_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic [Q_W-1:0]     quot,
  output bfs_pkg::div_stat_t stat
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [Q_W-1:0]   lo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic             fits;

  // next partial remainder
  always_comb begin
    trial = {rem, lo[Q_W-1]};
    fits  = trial >= {1'b0, den_q};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(Q_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift in dividend bits, shift out quotient bits
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:Q_W];
      lo    <= num[Q_W-1:0];
      den_q <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      lo  <= {lo[Q_W-2:0], fits};
    end
  end

  assign quot      = lo;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: src/bilateral_filter_support_weighted.sv
// ----------------------------------------------------------------------------
// bilateral_filter_support_weighted - support-weighted bilateral filter
// Tiles in raster order into a line store; each full window is walked tap by
// tap through one shared weight path and one shared divider.
// ----------------------------------------------------------------------------
//   channel   dir  payload                                         accepted when
//   pixels    in   sample, support, tile_first                      valid & ready
//   results   out  filtered, center_col, center_row, tile_last      valid & ready
//   cfg       in   index, data                                      valid & ready
//
// An item that completes no window leaves the filter ready for the next. One that
// does walks every tap, using the divider for each tap whose support differs from
// the centre's with neither zero, and for the final mean unless every weight is zero.
// Reset is synchronous and clears control state only, not the line store.
// A stalled result waits in the output register while the next item is
// taken; the walk after it waits only if the register is still full.
// ----------------------------------------------------------------------------
module bilateral_filter_support_weighted #(
  parameter int MAX_TILE   = bfs_pkg::DEF_MAX_TILE,
  parameter int MAX_RADIUS = bfs_pkg::DEF_MAX_RADIUS
) (
  input logic       clk,
  input logic       rst,
  bfs_in_if.sink    pixels,
  bfs_out_if.source results,
  bfs_cfg_if.sink   cfg
);

  localparam int LINES = 2 * MAX_RADIUS + 1;
  localparam int DEPTH = LINES * MAX_TILE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(MAX_TILE);
  localparam int LW    = $clog2(LINES);
  localparam int TW_B  = $clog2(MAX_TILE + 1);
  localparam int TCW   = (TW_B > 9) ? TW_B + 1 : 10;
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int KW    = $clog2(LINES);
  localparam int DS_W  = $clog2(2 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int WT_W  = 24;
  localparam int SW_W  = WT_W + $clog2(LINES * LINES + 1);
  localparam int SV_W  = SW_W + bfs_pkg::SAMPLE_BITS;
  localparam int SB    = bfs_pkg::SAMPLE_BITS;
  localparam int PB    = bfs_pkg::OUT_POS_BITS;
  localparam int PW    = bfs_pkg::ARG_BITS + bfs_pkg::EXP_IW + 1;

  // configuration registers
  logic [8:0]  tile_width;
  logic [1:0]  window_radius;
  logic [31:0] spatial_scale;
  logic [31:0] range_scale;
  logic        sup_enable;

  // position state
  logic [CW-1:0] col_count;
  logic [CW-1:0] row_count;
  logic [LW-1:0] line_count;

  // sequencer
  bfs_pkg::state_t state;
  bfs_pkg::state_t state_next;

  // walk registers
  logic [RW-1:0]  r_lat;
  logic [CW-1:0]  col0;
  logic [LW-1:0]  cline;
  logic [LW-1:0]  tline;
  logic [KW-1:0]  kx;
  logic [KW-1:0]  ky;
  logic [PB-1:0]  ccol;
  logic [PB-1:0]  crow;
  logic           last;
  logic [SB-1:0]  cv;
  logic [15:0]    cs;
  logic [SB-1:0]  tv;
  logic [15:0]    ts;
  logic [SB-1:0]  d;
  logic [DS_W-1:0] ds2;
  logic [2*SB-1:0] dr2;
  logic [32:0]    ab2;
  logic [16:0]    ssum;
  logic [15:0]    rel;
  logic [2*SB+15:0] pr;
  logic [DS_W+31:0] as_p;
  logic [63:0]    ar_p;
  logic [bfs_pkg::ARG_BITS-1:0] as_c;
  logic [bfs_pkg::EXP_W-1:0] e;
  logic           wz;
  logic [WT_W-1:0] w;
  logic [SW_W-1:0] sw;
  logic [SV_W-1:0] sv;
  logic [SB-1:0]  res;

  // output register
  logic          out_full;
  logic [SB-1:0] out_filtered;
  logic [PB-1:0] out_col;
  logic [PB-1:0] out_row;
  logic          out_last;

  // combinational helpers
  logic [TCW-1:0] tw;
  logic [RW-1:0]  r_eff;
  logic [TCW-1:0] c0;
  logic [TCW-1:0] r0;
  logic [LW-1:0]  l0;
  logic [TCW-1:0] c1;
  logic [TCW-1:0] r1;
  logic [LW-1:0]  l1;
  logic           produce;
  logic           accept;
  logic [LW:0]    cl_sum;
  logic [LW:0]    sl_sum;
  logic           tap_last;
  logic [KW-1:0]  dx;
  logic [KW-1:0]  dy;
  logic [bfs_pkg::ARG_BITS-1:0] ar_c;
  logic [bfs_pkg::ARG_BITS:0]   a_sum;
  logic [PW-1:0]  a_prod;
  logic           out_load;

  // memory and divider connections
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [bfs_pkg::WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [bfs_pkg::WORD_BITS-1:0] mem_rdata;
  logic                          div_start;
  logic [SV_W-1:0]               div_num;
  logic [SW_W-1:0]               div_den;
  logic [SB-1:0]                 div_quot;
  bfs_pkg::div_stat_t            dstat;

  bfs_line_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bfs_div #(.DEN_W(SW_W), .Q_W(SB), .NUM_W(SV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .stat  (dstat)
  );

  // take configuration writes
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width    <= bfs_pkg::RST_TILE_WIDTH;
      window_radius <= bfs_pkg::RST_WINDOW_RADIUS;
      spatial_scale <= bfs_pkg::RST_SPATIAL_SCALE;
      range_scale   <= bfs_pkg::RST_RANGE_SCALE;
      sup_enable    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        bfs_pkg::REG_TILE_WIDTH:    tile_width    <= cfg.data[8:0];
        bfs_pkg::REG_WINDOW_RADIUS: window_radius <= cfg.data[1:0];
        bfs_pkg::REG_SPATIAL_SCALE: spatial_scale <= cfg.data;
        bfs_pkg::REG_RANGE_SCALE:   range_scale   <= cfg.data;
        bfs_pkg::REG_SUP_ENABLE:    sup_enable    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // clamp tile side and radius; place the incoming item
  always_comb begin
    if (tile_width < 9'd3) begin
      tw = TCW'(3);
    end else if (TCW'(tile_width) > TCW'(MAX_TILE)) begin
      tw = TCW'(MAX_TILE);
    end else begin
      tw = TCW'(tile_width);
    end
    r_eff = (32'(window_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(window_radius);
    c0 = pixels.tile_first ? '0 : TCW'(col_count);
    r0 = pixels.tile_first ? '0 : TCW'(row_count);
    l0 = pixels.tile_first ? '0 : line_count;
    if (c0 >= tw) begin
      c0 = '0;
    end
    if (r0 >= tw) begin
      r0 = '0;
      l0 = '0;
    end
    c1 = c0 + 1'b1;
    r1 = r0;
    l1 = l0;
    if (c1 >= tw) begin
      c1 = '0;
      r1 = r0 + 1'b1;
      l1 = (l0 == LW'(LINES - 1)) ? '0 : LW'(l0 + 1'b1);
      if (r1 >= tw) begin
        r1 = '0;
        l1 = '0;
      end
    end
    produce = (r0 >= (TCW'(r_eff) << 1)) && (c0 >= (TCW'(r_eff) << 1));
    cl_sum  = (LW+1)'(l0) + (LW+1)'(LINES) - (LW+1)'(r_eff);
    if (cl_sum >= (LW+1)'(LINES)) begin
      cl_sum = cl_sum - (LW+1)'(LINES);
    end
    sl_sum  = (LW+1)'(l0) + (LW+1)'(LINES) - ((LW+1)'(r_eff) << 1);
    if (sl_sum >= (LW+1)'(LINES)) begin
      sl_sum = sl_sum - (LW+1)'(LINES);
    end
  end

  assign accept = pixels.valid && pixels.ready;

  // store the item in its line
  assign mem_we    = accept;
  assign mem_waddr = AW'(l0) * AW'(MAX_TILE) + AW'(c0);
  assign mem_wdata = {pixels.sample, sup_enable ? pixels.support : bfs_pkg::UNIT_SUPPORT};

  // advance the position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count  <= '0;
      row_count  <= '0;
      line_count <= '0;
    end else if (accept) begin
      col_count  <= CW'(c1);
      row_count  <= CW'(r1);
      line_count <= l1;
    end
  end

  // tap distances and exponent argument
  always_comb begin
    dx = (kx > KW'(r_lat)) ? KW'(kx - KW'(r_lat)) : KW'(KW'(r_lat) - kx);
    dy = (ky > KW'(r_lat)) ? KW'(ky - KW'(r_lat)) : KW'(KW'(r_lat) - ky);
    tap_last = (kx == KW'({r_lat, 1'b0})) && (ky == KW'({r_lat, 1'b0}));
    if (ar_p > (64'd1 << 44)) begin
      ar_c = bfs_pkg::ARG_CAP;
    end else begin
      ar_c = bfs_pkg::ARG_BITS'(ar_p >> 24);
    end
    a_sum  = (bfs_pkg::ARG_BITS+1)'(as_c) + (bfs_pkg::ARG_BITS+1)'(ar_c);
    a_prod = PW'(a_sum) * PW'(bfs_pkg::EXP_ENTRIES);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bfs_pkg::ST_IDLE:  if (accept && produce) state_next = bfs_pkg::ST_CREAD;
      bfs_pkg::ST_CREAD: state_next = bfs_pkg::ST_CCAP;
      bfs_pkg::ST_CCAP:  state_next = bfs_pkg::ST_TREAD;
      bfs_pkg::ST_TREAD: state_next = bfs_pkg::ST_TCAP;
      bfs_pkg::ST_TCAP:  state_next = bfs_pkg::ST_TMUL1;
      bfs_pkg::ST_TMUL1: state_next = bfs_pkg::ST_TREL;
      bfs_pkg::ST_TREL: begin
        if (cs == 16'd0 || ts == 16'd0 || cs == ts) begin
          state_next = bfs_pkg::ST_TMUL2;
        end else begin
          state_next = bfs_pkg::ST_TRDIV;
        end
      end
      bfs_pkg::ST_TRDIV: if (dstat.done) state_next = bfs_pkg::ST_TMUL2;
      bfs_pkg::ST_TMUL2: state_next = bfs_pkg::ST_TMUL3;
      bfs_pkg::ST_TMUL3: state_next = bfs_pkg::ST_TWGT;
      bfs_pkg::ST_TWGT:  state_next = bfs_pkg::ST_TW;
      bfs_pkg::ST_TW:    state_next = bfs_pkg::ST_TACC;
      bfs_pkg::ST_TACC:  state_next = tap_last ? bfs_pkg::ST_FDIV : bfs_pkg::ST_TREAD;
      bfs_pkg::ST_FDIV:  state_next = (sw == '0) ? bfs_pkg::ST_DONE : bfs_pkg::ST_FWAIT;
      bfs_pkg::ST_FWAIT: if (dstat.done) state_next = bfs_pkg::ST_DONE;
      bfs_pkg::ST_DONE:  if (out_load) state_next = bfs_pkg::ST_IDLE;
      default:           state_next = bfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // outputs of the sequencer: read address, divider start, handshakes
  always_comb begin
    pixels.ready = 1'b0;
    mem_raddr    = AW'(tline) * AW'(MAX_TILE) + AW'(col0) + AW'(kx);
    div_start    = 1'b0;
    div_num      = SV_W'(ab2);
    div_den      = SW_W'(ssum);
    out_load     = 1'b0;
    case (state)
      bfs_pkg::ST_IDLE:  pixels.ready = 1'b1;
      bfs_pkg::ST_CREAD: mem_raddr = AW'(cline) * AW'(MAX_TILE) + AW'(col0) + AW'(r_lat);
      bfs_pkg::ST_TREL:  div_start = !(cs == 16'd0 || ts == 16'd0 || cs == ts);
      bfs_pkg::ST_FDIV: begin
        div_start = (sw != '0);
        div_num   = sv + SV_W'(sw >> 1);
        div_den   = sw;
      end
      bfs_pkg::ST_DONE:  out_load = !out_full || results.ready;
      default: ;
    endcase
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state)
      bfs_pkg::ST_IDLE: begin
        r_lat <= r_eff;
        col0  <= CW'(c0 - (TCW'(r_eff) << 1));
        cline <= LW'(cl_sum);
        tline <= LW'(sl_sum);
        ccol  <= PB'(c0 - TCW'(r_eff));
        crow  <= PB'(r0 - TCW'(r_eff));
        last  <= (r0 == tw - 1'b1) && (c0 == tw - 1'b1);
        kx    <= '0;
        ky    <= '0;
        sw    <= '0;
        sv    <= '0;
      end
      bfs_pkg::ST_CCAP: begin
        cv <= mem_rdata[bfs_pkg::WORD_BITS-1:bfs_pkg::SUP_BITS];
        cs <= mem_rdata[bfs_pkg::SUP_BITS-1:0];
      end
      bfs_pkg::ST_TCAP: begin
        tv  <= mem_rdata[bfs_pkg::WORD_BITS-1:bfs_pkg::SUP_BITS];
        ts  <= mem_rdata[bfs_pkg::SUP_BITS-1:0];
        d   <= (mem_rdata[bfs_pkg::WORD_BITS-1:bfs_pkg::SUP_BITS] > cv)
               ? SB'(mem_rdata[bfs_pkg::WORD_BITS-1:bfs_pkg::SUP_BITS] - cv)
               : SB'(cv - mem_rdata[bfs_pkg::WORD_BITS-1:bfs_pkg::SUP_BITS]);
        ds2 <= DS_W'(DS_W'(dx) * DS_W'(dx) + DS_W'(dy) * DS_W'(dy));
      end
      bfs_pkg::ST_TMUL1: begin
        dr2  <= (2*SB)'(d) * (2*SB)'(d);
        ab2  <= {32'(cs) * 32'(ts), 1'b0};
        ssum <= 17'(cs) + 17'(ts);
      end
      bfs_pkg::ST_TREL: begin
        if (cs == 16'd0 || ts == 16'd0) begin
          rel <= 16'd0;
        end else begin
          rel <= cs;
        end
      end
      bfs_pkg::ST_TRDIV: begin
        if (dstat.done) begin
          rel <= div_quot[15:0];
        end
      end
      bfs_pkg::ST_TMUL2: begin
        pr   <= (2*SB+16)'(dr2) * (2*SB+16)'(rel);
        as_p <= (DS_W+32)'(ds2) * (DS_W+32)'(spatial_scale);
      end
      bfs_pkg::ST_TMUL3: begin
        ar_p <= 64'(32'(pr >> bfs_pkg::RANGE_SHIFT)) * 64'(range_scale);
        if ((as_p >> 8) > (DS_W+32)'(bfs_pkg::ARG_CAP)) begin
          as_c <= bfs_pkg::ARG_CAP;
        end else begin
          as_c <= bfs_pkg::ARG_BITS'(as_p >> 8);
        end
      end
      bfs_pkg::ST_TWGT: begin
        wz <= a_sum >= (bfs_pkg::ARG_BITS+1)'(bfs_pkg::ARG_CAP);
        e  <= bfs_pkg::EXP_TAB[a_prod[20 +: bfs_pkg::EXP_IW]];
      end
      bfs_pkg::ST_TW: begin
        w <= wz ? '0 : WT_W'((33'(e) * 33'(ts)) >> 8);
      end
      bfs_pkg::ST_TACC: begin
        sw <= sw + SW_W'(w);
        sv <= sv + SV_W'(w) * SV_W'(tv);
        if (kx == KW'({r_lat, 1'b0})) begin
          kx    <= '0;
          ky    <= ky + 1'b1;
          tline <= (tline == LW'(LINES - 1)) ? '0 : LW'(tline + 1'b1);
        end else begin
          kx <= kx + 1'b1;
        end
      end
      bfs_pkg::ST_FDIV: begin
        res <= cv;
      end
      bfs_pkg::ST_FWAIT: begin
        if (dstat.done) begin
          res <= div_quot;
        end
      end
      default: ;
    endcase
  end

  // output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (out_load) begin
      out_full <= 1'b1;
    end else if (results.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_filtered <= res;
      out_col      <= ccol;
      out_row      <= crow;
      out_last     <= last;
    end
  end

  assign results.valid      = out_full;
  assign results.filtered   = out_filtered;
  assign results.center_col = out_col;
  assign results.center_row = out_row;
  assign results.tile_last  = out_last;

  // divider reports completion only while the walk waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == bfs_pkg::ST_TRDIV || state == bfs_pkg::ST_FWAIT))
    else $error("divider finished outside a wait state");

  // a divider start never lands on a busy divider
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !dstat.busy)
    else $error("divider restarted while busy");

  // a finished result always reaches the output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == bfs_pkg::ST_DONE && !out_full) |=> (out_full && state == bfs_pkg::ST_IDLE))
    else $error("result not loaded");

  // the walk never runs past the window
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bfs_pkg::ST_TREAD) |-> (ky <= KW'({r_lat, 1'b0})))
    else $error("tap walk out of window");

endmodule
